>>> rtl/bdpc_pkg.sv
package bdpc_pkg;

    // APB register map: word index taken from paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_PIN_INVERT     = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE_COUNT = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG_HOLD      = 3'd2;
    localparam logic [IDX_W-1:0] REG_VERYLONG_HOLD  = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_SHORT_HOLD = 3'd4;

    // Register reset values
    localparam logic        RST_PIN_INVERT     = 1'b1;
    localparam logic [7:0]  RST_DEBOUNCE_COUNT = 8'd2;
    localparam logic [15:0] RST_LONG_HOLD      = 16'd150;
    localparam logic [15:0] RST_VERYLONG_HOLD  = 16'd500;
    localparam logic [15:0] RST_MIN_SHORT_HOLD = 16'd3;

    // Stream widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 8;

    // One classified tick
    typedef struct packed {
        logic verylong_event;
        logic long_event;
        logic short_event;
        logic pressed_state;
    } result_t;

endpackage

>>> rtl/bdpc_out_buf.sv
// Two-entry output buffer: output register plus skid register.
module bdpc_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bdpc_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bdpc_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    bdpc_pkg::result_t out_data_reg, out_data_next;
    bdpc_pkg::result_t skid_data_reg, skid_data_next;
    logic              push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next-state for the two entries
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (push) begin
            if (!out_valid_reg || out_ready) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

>>> rtl/button_debounce_press_classifier.sv
// Button debouncer and press classifier. Each s_ transaction is one poll
// tick carrying the raw pin level; each produces exactly one m_ transaction
// with the debounced state and the short, long and very-long event flags.
// The block takes one tick per clock cycle while s_tready is high: the debounce
// and hold counters update in the cycle a tick is accepted, and the result is
// registered in the output register, or in the skid register while the output
// register is full. A two-entry output buffer lets a new tick enter while one
// result still waits; s_tready drops only when both entries are full. Thresholds
// are set over the APB port at byte offsets 0x00 (pin_invert, 1 = low pin reads
// as pressed), 0x04 (debounce_count), 0x08 (long_hold), 0x0C (verylong_hold)
// and 0x10 (min_short_hold), written while the stream is idle.
module button_debounce_press_classifier #(
    parameter int unsigned HOLD_BITS     = 16,
    parameter int unsigned DEBOUNCE_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bdpc_pkg::ADDR_W-1:0]         paddr,
    input  logic [bdpc_pkg::DATA_W-1:0]         pwdata,
    output logic [bdpc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    // Input ticks
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdpc_pkg::S_TDATA_W-1:0]      s_tdata,  // [0] pin_level, [7:1] zero
    // Results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bdpc_pkg::M_TDATA_W-1:0]      m_tdata   // [0] pressed_state,
                                                          // [1] short_event,
                                                          // [2] long_event,
                                                          // [3] verylong_event,
                                                          // [7:4] zero
);

    // Compare widths cover both the counter and its 8/16-bit register
    localparam int unsigned DCW = (DEBOUNCE_BITS > 8) ? DEBOUNCE_BITS : 8;
    localparam int unsigned HCW = (HOLD_BITS > 16) ? HOLD_BITS : 16;

    // Configuration registers
    logic        pin_invert_reg;
    logic [7:0]  debounce_count_reg;
    logic [15:0] long_hold_reg;
    logic [15:0] verylong_hold_reg;
    logic [15:0] min_short_hold_reg;

    // Classifier state
    logic                     stable_pressed_reg, stable_pressed_next;
    logic [DEBOUNCE_BITS-1:0] mismatch_count_reg, mismatch_count_next;
    logic [HOLD_BITS-1:0]     hold_ticks_reg, hold_ticks_next;
    logic                     long_fired_reg, long_fired_next;
    logic                     verylong_fired_reg, verylong_fired_next;

    logic                       cfg_write;
    logic [bdpc_pkg::IDX_W-1:0] cfg_idx;
    logic                       accept;
    logic                       buf_ready;
    logic                       reading;
    logic [DEBOUNCE_BITS-1:0]   mismatch_inc;
    logic [HOLD_BITS-1:0]       hold_inc;
    logic [HCW-1:0]             hold_ext;
    logic                       deb_reached;
    bdpc_pkg::result_t          res;
    bdpc_pkg::result_t          out_res;

    // APB write decode
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[bdpc_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_invert_reg     <= bdpc_pkg::RST_PIN_INVERT;
            debounce_count_reg <= bdpc_pkg::RST_DEBOUNCE_COUNT;
            long_hold_reg      <= bdpc_pkg::RST_LONG_HOLD;
            verylong_hold_reg  <= bdpc_pkg::RST_VERYLONG_HOLD;
            min_short_hold_reg <= bdpc_pkg::RST_MIN_SHORT_HOLD;
        end else if (cfg_write) begin
            case (cfg_idx)
                bdpc_pkg::REG_PIN_INVERT:     pin_invert_reg     <= pwdata[0];
                bdpc_pkg::REG_DEBOUNCE_COUNT: debounce_count_reg <= pwdata[7:0];
                bdpc_pkg::REG_LONG_HOLD:      long_hold_reg      <= pwdata[15:0];
                bdpc_pkg::REG_VERYLONG_HOLD:  verylong_hold_reg  <= pwdata[15:0];
                bdpc_pkg::REG_MIN_SHORT_HOLD: min_short_hold_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // APB read mux
    always_comb begin
        case (cfg_idx)
            bdpc_pkg::REG_PIN_INVERT:     prdata = {31'd0, pin_invert_reg};
            bdpc_pkg::REG_DEBOUNCE_COUNT: prdata = {24'd0, debounce_count_reg};
            bdpc_pkg::REG_LONG_HOLD:      prdata = {16'd0, long_hold_reg};
            bdpc_pkg::REG_VERYLONG_HOLD:  prdata = {16'd0, verylong_hold_reg};
            bdpc_pkg::REG_MIN_SHORT_HOLD: prdata = {16'd0, min_short_hold_reg};
            default:                      prdata = '0;
        endcase
    end

    assign s_tready = buf_ready;
    assign accept   = s_tvalid && s_tready;
    assign reading  = pin_invert_reg ? !s_tdata[0] : s_tdata[0];

    // Saturating counter increments
    assign mismatch_inc = (&mismatch_count_reg) ? mismatch_count_reg
                                                : mismatch_count_reg + 1'b1;
    assign hold_inc = (stable_pressed_reg && !(&hold_ticks_reg)) ? hold_ticks_reg + 1'b1
                                                                 : hold_ticks_reg;
    assign hold_ext = HCW'(hold_inc);

    // Threshold clamps to the counter maximum when the register is larger
    assign deb_reached = (DCW'(mismatch_inc) >= DCW'(debounce_count_reg))
                      || (&mismatch_inc);

    // Per-tick classification
    always_comb begin
        stable_pressed_next = stable_pressed_reg;
        mismatch_count_next = mismatch_count_reg;
        hold_ticks_next     = hold_inc;
        long_fired_next     = long_fired_reg;
        verylong_fired_next = verylong_fired_reg;
        res                 = '0;
        if (reading != stable_pressed_reg) begin
            mismatch_count_next = mismatch_inc;
            if (deb_reached) begin
                stable_pressed_next = reading;
                mismatch_count_next = '0;
                if (reading) begin
                    hold_ticks_next     = '0;
                    long_fired_next     = 1'b0;
                    verylong_fired_next = 1'b0;
                end else if (!long_fired_reg && !verylong_fired_reg
                             && hold_ext < HCW'(long_hold_reg)
                             && hold_ext >= HCW'(min_short_hold_reg)) begin
                    res.short_event = 1'b1;
                end
            end
        end else begin
            mismatch_count_next = '0;
            if (stable_pressed_reg && !long_fired_reg
                && hold_ext >= HCW'(long_hold_reg)) begin
                long_fired_next = 1'b1;
                res.long_event  = 1'b1;
            end
            if (stable_pressed_reg && long_fired_next && !verylong_fired_reg
                && hold_ext >= HCW'(verylong_hold_reg)) begin
                verylong_fired_next = 1'b1;
                res.verylong_event  = 1'b1;
            end
        end
        res.pressed_state = stable_pressed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_pressed_reg <= 1'b0;
            mismatch_count_reg <= '0;
            hold_ticks_reg     <= '0;
            long_fired_reg     <= 1'b0;
            verylong_fired_reg <= 1'b0;
        end else if (accept) begin
            stable_pressed_reg <= stable_pressed_next;
            mismatch_count_reg <= mismatch_count_next;
            hold_ticks_reg     <= hold_ticks_next;
            long_fired_reg     <= long_fired_next;
            verylong_fired_reg <= verylong_fired_next;
        end
    end

    // Result buffering
    bdpc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {4'd0, out_res.verylong_event, out_res.long_event,
                      out_res.short_event, out_res.pressed_state};

    // Checks
    a_vlong_needs_long: assert property (@(posedge aclk) disable iff (!aresetn)
        verylong_fired_reg |-> long_fired_reg)
        else $error("very-long flag set without long flag");

    a_match_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && reading == stable_pressed_reg) |=> mismatch_count_reg == '0)
        else $error("matching tick did not clear mismatch count");

    a_long_while_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2] || m_tdata[3])) |-> m_tdata[0])
        else $error("long event reported while released");

    a_short_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.short_event) |=> !stable_pressed_reg)
        else $error("short event without release");

endmodule
